FILE: design/qdsem_pkg.sv
package qdsem_pkg;

  localparam int SAMPLE_W = 18;
  localparam int PHASE_W  = 16;
  localparam int SLOW_SH  = 8;
  localparam int FAST_SH  = 4;
  localparam int CORD_N   = 16;
  localparam int XY_W     = 30;
  localparam int Z_W      = 33;
  localparam int MA_W     = 30;
  localparam int MB_W     = 21;
  localparam int P_W      = MA_W + MB_W;
  localparam int ROT_W    = 23;
  localparam int ERR_W    = 19;
  localparam int MEAN_W   = 18;

  localparam logic [MB_W-1:0]   GAIN_Q20    = 21'd636751;
  localparam logic [MEAN_W-1:0] WHITE_HALF  = 18'd21847;
  localparam logic [MEAN_W-1:0] DIST_MAX    = 18'd131072;

  // Configuration register indexes.
  localparam logic [1:0] REG_PHASE_RATE = 2'd0;
  localparam logic [1:0] REG_QUARTER    = 2'd1;
  localparam logic [1:0] REG_CONJ       = 2'd2;
  localparam logic [1:0] REG_SLACK      = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_ROT, S_GX, S_GY, S_SLICE, S_SQR, S_SQI, S_UPD, S_FIN
  } st_t;

  typedef struct packed {
    logic       load;
    logic       rot;
    logic       gx;
    logic       gy;
    logic       slc;
    logic       sqr;
    logic       sqi;
    logic       upd;
    logic       oload;
    logic [3:0] step;
  } cmd_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [Z_W-1:0] atan_turn(input logic [3:0] i);
    logic [Z_W-1:0] a;
    case (i)
      4'd0:    a = 33'd536870912;
      4'd1:    a = 33'd316933406;
      4'd2:    a = 33'd167458907;
      4'd3:    a = 33'd85004756;
      4'd4:    a = 33'd42667331;
      4'd5:    a = 33'd21354465;
      4'd6:    a = 33'd10679838;
      4'd7:    a = 33'd5340245;
      4'd8:    a = 33'd2670163;
      4'd9:    a = 33'd1335087;
      4'd10:   a = 33'd667544;
      4'd11:   a = 33'd333772;
      4'd12:   a = 33'd166886;
      4'd13:   a = 33'd83443;
      4'd14:   a = 33'd41722;
      default: a = 33'd20861;
    endcase
    return a;
  endfunction

endpackage

FILE: design/qdsem_ctrl.sv
module qdsem_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              in_action,
  input  logic              out_tready,
  output logic              in_tready,
  output logic              out_tvalid,
  output qdsem_pkg::cmd_t   cmd
);

  qdsem_pkg::st_t state_r, state_nxt;
  logic [3:0]     step_r, step_nxt;
  logic           ovld_r, ovld_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      qdsem_pkg::S_IDLE: begin
        step_nxt = 4'd0;
        if (in_fire) begin
          state_nxt = in_action ? qdsem_pkg::S_FIN : qdsem_pkg::S_ROT;
        end
      end
      qdsem_pkg::S_ROT: begin
        step_nxt = step_r + 4'd1;
        if (step_r == 4'(qdsem_pkg::CORD_N - 1)) begin
          state_nxt = qdsem_pkg::S_GX;
        end
      end
      qdsem_pkg::S_GX:    state_nxt = qdsem_pkg::S_GY;
      qdsem_pkg::S_GY:    state_nxt = qdsem_pkg::S_SLICE;
      qdsem_pkg::S_SLICE: state_nxt = qdsem_pkg::S_SQR;
      qdsem_pkg::S_SQR:   state_nxt = qdsem_pkg::S_SQI;
      qdsem_pkg::S_SQI:   state_nxt = qdsem_pkg::S_UPD;
      qdsem_pkg::S_UPD:   state_nxt = qdsem_pkg::S_FIN;
      qdsem_pkg::S_FIN: begin
        if (!ovld_r || out_tready) begin
          state_nxt = qdsem_pkg::S_IDLE;
        end
      end
      default: state_nxt = qdsem_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.step  = step_r;
    cmd.load  = (state_r == qdsem_pkg::S_IDLE) && in_fire;
    cmd.rot   = (state_r == qdsem_pkg::S_ROT);
    cmd.gx    = (state_r == qdsem_pkg::S_GX);
    cmd.gy    = (state_r == qdsem_pkg::S_GY);
    cmd.slc   = (state_r == qdsem_pkg::S_SLICE);
    cmd.sqr   = (state_r == qdsem_pkg::S_SQR);
    cmd.sqi   = (state_r == qdsem_pkg::S_SQI);
    cmd.upd   = (state_r == qdsem_pkg::S_UPD);
    cmd.oload = (state_r == qdsem_pkg::S_FIN) && (!ovld_r || out_tready);
    in_tready = (state_r == qdsem_pkg::S_IDLE);
    out_tvalid = ovld_r;
    ovld_nxt  = cmd.oload ? 1'b1 : (out_tready ? 1'b0 : ovld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qdsem_pkg::S_IDLE;
      step_r  <= 4'd0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  a_rot_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qdsem_pkg::S_ROT && step_r == 4'(qdsem_pkg::CORD_N - 1))
      |=> state_r == qdsem_pkg::S_GX)
    else $error("rotation did not end after the last step");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.oload |-> (!ovld_r || out_tready))
    else $error("output register loaded while holding an untaken word");
  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qdsem_pkg::S_FIN && state_nxt == qdsem_pkg::S_IDLE) |=> ovld_r)
    else $error("finished item produced no output word");

endmodule

FILE: design/qdsem_dp.sv
module qdsem_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  qdsem_pkg::cmd_t                     cmd,
  input  logic                                in_action,
  input  logic signed [qdsem_pkg::SAMPLE_W-1:0] in_re,
  input  logic signed [qdsem_pkg::SAMPLE_W-1:0] in_im,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_addr,
  input  logic [15:0]                         cfg_wdata,
  output logic [71:0]                         out_word,
  output logic                                out_health
);

  localparam int SW = qdsem_pkg::SAMPLE_W;
  localparam int XW = qdsem_pkg::XY_W;
  localparam int ZW = qdsem_pkg::Z_W;
  localparam int MW = qdsem_pkg::MEAN_W;
  localparam int EW = qdsem_pkg::ERR_W;
  localparam int RW = qdsem_pkg::ROT_W;
  localparam int PW = qdsem_pkg::P_W;

  // Configuration registers.
  logic [15:0] rate_r;
  logic [1:0]  qt_r;
  logic        conj_r;
  logic [11:0] slack_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= '0;
      qt_r    <= '0;
      conj_r  <= 1'b0;
      slack_r <= 12'd512;
    end else if (cfg_we) begin
      case (cfg_addr)
        qdsem_pkg::REG_PHASE_RATE: rate_r  <= cfg_wdata;
        qdsem_pkg::REG_QUARTER:    qt_r    <= cfg_wdata[1:0];
        qdsem_pkg::REG_CONJ:       conj_r  <= cfg_wdata[0];
        qdsem_pkg::REG_SLACK:      slack_r <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // Loop state.
  logic [15:0]          acc_r;
  logic [MW-1:0]        slow_r, fast_r, base_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic signed [PW-1:0] prod_r;
  logic signed [RW-1:0] dr_r;
  logic signed [EW-1:0] er_r, ei_r;
  logic signed [7:0]    decr_r, deci_r;
  logic [PW-1:0]        sq_r;
  logic [MW-1:0]        dist_r;
  logic [71:0]          ow_r;
  logic                 oh_r;

  // Phase split into a quadrant and a residual for the CORDIC.
  logic [15:0]          ph;
  logic [1:0]           quad;
  logic [15:0]          rem16;
  logic signed [XW-1:0] xs, ys, x0, y0;
  logic signed [ZW-1:0] z0;

  always_comb begin
    ph    = acc_r + rate_r;
    quad  = 2'((ph + 16'h2000) >> 14);
    rem16 = ph - {quad, 14'd0};
    z0    = -ZW'(signed'({rem16, 16'd0}));
    xs    = XW'(in_re) <<< 8;
    ys    = XW'(in_im) <<< 8;
    case (quad)
      2'd1:    begin x0 = ys;  y0 = -xs; end
      2'd2:    begin x0 = -xs; y0 = -ys; end
      2'd3:    begin x0 = -ys; y0 = xs;  end
      default: begin x0 = xs;  y0 = ys;  end
    endcase
  end

  // Shared multiplier operands.
  logic signed [qdsem_pkg::MA_W-1:0] ma;
  logic signed [qdsem_pkg::MB_W-1:0] mb;
  logic signed [RW-1:0]              rnd;

  always_comb begin
    ma = x_r;
    mb = signed'(qdsem_pkg::GAIN_Q20);
    if (cmd.gy) begin
      ma = y_r;
    end else if (cmd.sqr) begin
      ma = XW'(er_r);
      mb = qdsem_pkg::MB_W'(er_r);
    end else if (cmd.sqi) begin
      ma = XW'(ei_r);
      mb = qdsem_pkg::MB_W'(ei_r);
    end
    rnd = RW'((prod_r + (PW'(1) <<< 27)) >>> 28);
  end

  // Conjugate, quarter turns, saturation and slicing.
  logic signed [RW:0]   pr, pi, tr, ti;
  logic signed [SW-1:0] vr, vi;
  logic signed [7:0]    sdr, sdi;
  logic signed [EW-1:0] ser, sei;

  function automatic logic signed [SW-1:0] sat_s(input logic signed [RW:0] v);
    logic signed [RW:0] hi, lo;
    hi = (RW+1)'((1 <<< (SW - 1)) - 1);
    lo = -(RW+1)'(1 <<< (SW - 1));
    if (v > hi)      return SW'(hi);
    else if (v < lo) return SW'(lo);
    else             return SW'(v);
  endfunction

  function automatic logic signed [7:0] slice_d(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] d;
    d = ((v >>> 11) <<< 1) + SW'(1);
    if (d > SW'(127))       return 8'sd127;
    else if (d < -SW'(127)) return -8'sd127;
    else                    return 8'(d);
  endfunction

  always_comb begin
    pr = (RW+1)'(dr_r);
    pi = conj_r ? -(RW+1)'(rnd) : (RW+1)'(rnd);
    case (qt_r)
      2'd1:    begin tr = -pi; ti = pr;  end
      2'd2:    begin tr = -pr; ti = -pi; end
      2'd3:    begin tr = pi;  ti = -pr; end
      default: begin tr = pr;  ti = pi;  end
    endcase
    vr  = sat_s(tr);
    vi  = sat_s(ti);
    sdr = slice_d(vr);
    sdi = slice_d(vi);
    ser = EW'(vr) - (EW'(sdr) <<< 10);
    sei = EW'(vi) - (EW'(sdi) <<< 10);
  end

  // Squared distance and mean updates.
  logic [PW-1:0]        sqs;
  logic [MW-1:0]        dist_v;
  logic signed [MW:0]   dsl, dfa;
  logic [MW-1:0]        slow_n, fast_n;

  always_comb begin
    sqs    = (sq_r + prod_r + PW'(8)) >> 4;
    dist_v = (sqs > PW'(qdsem_pkg::DIST_MAX)) ? qdsem_pkg::DIST_MAX : MW'(sqs);
    dsl    = signed'({1'b0, dist_v}) - signed'({1'b0, slow_r});
    dfa    = signed'({1'b0, dist_v}) - signed'({1'b0, fast_r});
    slow_n = MW'(signed'({1'b0, slow_r}) + (dsl >>> qdsem_pkg::SLOW_SH));
    fast_n = MW'(signed'({1'b0, fast_r}) + (dfa >>> qdsem_pkg::FAST_SH));
  end

  // Health test on the registered means.
  logic [29:0] lhs, rhs;
  logic        hl;

  always_comb begin
    lhs = {4'd0, fast_r, 8'd0};
    rhs = 30'(base_r) * 30'(slack_r);
    hl  = !(fast_r >= qdsem_pkg::WHITE_HALF) &&
          !((base_r != '0) && (lhs > rhs));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      slow_r <= '0;
      fast_r <= '0;
      base_r <= '0;
    end else begin
      if (cmd.load) begin
        if (in_action) base_r <= slow_r;
        else           acc_r  <= ph;
      end
      if (cmd.upd) begin
        slow_r <= slow_n;
        fast_r <= fast_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= x0;
      y_r    <= y0;
      z_r    <= z0;
      decr_r <= '0;
      deci_r <= '0;
      dist_r <= '0;
    end
    if (cmd.rot) begin
      if (!z_r[ZW-1]) begin
        x_r <= x_r - (y_r >>> cmd.step);
        y_r <= y_r + (x_r >>> cmd.step);
        z_r <= z_r - signed'(qdsem_pkg::atan_turn(cmd.step));
      end else begin
        x_r <= x_r + (y_r >>> cmd.step);
        y_r <= y_r - (x_r >>> cmd.step);
        z_r <= z_r + signed'(qdsem_pkg::atan_turn(cmd.step));
      end
    end
    if (cmd.gx || cmd.gy || cmd.sqr || cmd.sqi) begin
      prod_r <= PW'(ma) * PW'(mb);
    end
    if (cmd.gy) dr_r <= rnd;
    if (cmd.slc) begin
      decr_r <= sdr;
      deci_r <= sdi;
      er_r   <= ser;
      ei_r   <= sei;
    end
    if (cmd.sqi) sq_r <= prod_r;
    if (cmd.upd) dist_r <= dist_v;
    if (cmd.oload) begin
      ow_r <= {2'd0, fast_r, slow_r, dist_r, deci_r, decr_r};
      oh_r <= hl;
    end
  end

  assign out_word   = ow_r;
  assign out_health = oh_r;

  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && in_action) |=> $stable(acc_r))
    else $error("baseline word moved the phase accumulator");
  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    (slow_r <= qdsem_pkg::DIST_MAX) && (fast_r <= qdsem_pkg::DIST_MAX))
    else $error("error mean left its range");
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |=> dist_r <= qdsem_pkg::DIST_MAX)
    else $error("distance not saturated");

endmodule

FILE: design/qam_derotate_slice_error_monitor.sv
// Channel | Direction | tdata (low bit first)                         | tuser
// in_     | slave     | sym_re[17:0], sym_im[35:18], zero pad to 40   | action
// out_    | master    | dec_re, dec_im, dist_res, err_slow_out,       | healthy
//         |           | err_fast_out, zero pad to 72                  |
// cfg_    | write     | cfg_addr selects register, cfg_wdata value    | -
//
// A symbol word passes through the iterative CORDIC rotator; then the single
// shared multiplier runs the two gain corrections and, after one slice step,
// the two error squares, followed by one mean update and the output load.
// The next word can be taken in the cycle after the output load.
// A baseline word skips the rotator and goes straight to the output load.
// Reset (rst_n low, synchronous) clears the phase, the error means and
// the baseline, and sets the slack register to 2.0.
// A finished result waits in the output register; the next word is taken
// while it waits, and only the final load stalls on out_tready.
module qam_derotate_slice_error_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // sym_re[17:0], sym_im[35:18]
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // dec_re, dec_im, dist_res, err_slow_out, err_fast_out
  output logic        out_tuser,  // healthy
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  qdsem_pkg::cmd_t cmd;
  logic            in_fire;

  // A word is taken when the controller sits idle and the source offers one.
  assign in_fire = in_tvalid && in_tready;

  qdsem_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_action  (in_tuser),
    .out_tready (out_tready),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  // The datapath holds the rotator, the shared multiplier, the slicer,
  // the error means and the output register.
  qdsem_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_action  (in_tuser),
    .in_re      (in_tdata[17:0]),
    .in_im      (in_tdata[35:18]),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_word   (out_tdata),
    .out_health (out_tuser)
  );

endmodule
